// ===== hdl/pvbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvbs_pkg
// Shared widths, constants and helpers of the phase vocoder bin shifter.
// ----------------------------------------------------------------------------
package pvbs_pkg;

    localparam int BIN_W        = 24;
    localparam int F0_W         = 20;
    localparam int RES_W        = 25;
    localparam int IN_W         = 88;
    localparam int OUT_W        = 56;
    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 8;
    localparam int VW           = 36;
    localparam int ZW           = 34;
    localparam int DIV_STEPS    = 16;
    localparam int RATIO_W      = 16;
    localparam int RATIO_FRAC   = 12;
    localparam int MAG_W        = 33;
    localparam int GAIN_W       = 30;
    localparam int PROD_W       = 64;

    localparam logic [GAIN_W-1:0]  INV_GAIN  = 30'd652032875;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 16'd4096;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;

    localparam logic signed [VW-1:0] RES_HI = 36'sd16777215;
    localparam logic signed [VW-1:0] RES_LO = -36'sd16777216;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166885,    32'd83443,     32'd41721,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [VW-1:0] v);
        logic signed [RES_W-1:0] r;
        priority if (v > RES_HI)
            r = RES_HI[RES_W-1:0];
        else if (v < RES_LO)
            r = RES_LO[RES_W-1:0];
        else
            r = v[RES_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/phase_vocoder_bin_shift.sv =====
// ----------------------------------------------------------------------------
// phase_vocoder_bin_shift
// Pitch shift of one spectrum frame per FFT_SIZE bins, one complex bin per
// request.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one bin per request: real, imag, original and corrected
//  pitch (pitches are read on bin zero of each frame only). The first bin
//  after reset is bin zero; bins count modulo FFT_SIZE.
//  m_axis returns one shifted bin per request, m_axis_tlast on bin FFT_SIZE-1.
//  Bins 0..FFT_SIZE/2 are rebuilt through vectoring cordic, phase update and
//  rotating cordic; upper bins return conjugates of stored lower bins.
//  The pipeline is one input stage, 25 vectoring cordic stages (pitch
//  divider runs alongside, one quotient bit per cordic step for the first
//  DIV_STEPS steps), four phase and gain stages, 25 rotating cordic stages,
//  one sign stage and the output register. Throughput is one bin per cycle
//  while neither an output stall nor the clearing pass holds the input.
//  After reset the phase memories are cleared, one entry per cycle, for all
//  FFT_SIZE/2+1 entries (257 at default); s_axis_tready is low meanwhile.
//  When m_axis_tready is low with a result waiting, the whole pipeline holds
//  and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module phase_vocoder_bin_shift #(
    parameter int FFT_SIZE   = 512,
    parameter int HOP_SIZE   = 128,
    parameter int PHASE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // bin_real, bin_imag, src_pitch, dst_pitch
    input  logic [pvbs_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // out_real, out_imag, zero fill
    output logic [pvbs_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);
    import pvbs_pkg::*;

    localparam int NBINS = FFT_SIZE / 2 + 1;
    localparam int IW    = $clog2(FFT_SIZE);
    localparam int NW    = $clog2(NBINS);
    localparam int PB    = PHASE_BITS;
    localparam int EAW   = PHASE_BITS + RATIO_FRAC;
    localparam longint unsigned E_FULL = longint'(HOP_SIZE) << PHASE_BITS;
    localparam longint unsigned E_QUO  = E_FULL / FFT_SIZE;
    localparam longint unsigned E_REM  = E_FULL % FFT_SIZE;
    localparam int NS = CORDIC_STEPS;

    typedef struct packed {
        logic           lower;
        logic           first;
        logic           last;
        logic [IW-1:0]  idx;
        logic [EAW-1:0] e;
    } ctl_t;

    logic en;
    logic accept;

    // clearing pass and bin counter
    logic          clr_busy_reg;
    logic [NW-1:0] clr_cnt_reg;
    logic [IW-1:0] pos_reg;
    logic [EAW-1:0] e_reg;
    logic [IW-1:0] erem_reg;
    logic [IW:0]   erem_sum;

    // input stage
    logic                    s0_v_reg;
    ctl_t                    s0_c_reg;
    logic signed [BIN_W-1:0] s0_re_reg, s0_im_reg;
    logic [32:0]             s0_n_reg;
    logic [F0_W-1:0]         s0_d_reg;

    // vectoring cordic and pitch divider
    logic                   vv_reg [0:NS];
    ctl_t                   vc_reg [0:NS];
    logic signed [VW-1:0]   vx_reg [0:NS];
    logic signed [VW-1:0]   vy_reg [0:NS];
    logic [31:0]            vz_reg [0:NS];
    logic                   vzero_reg [0:NS];
    logic [F0_W-1:0]        drem_reg [0:NS];
    logic [DIV_STEPS-1:0]   dlo_reg [0:NS];
    logic [RATIO_W-1:0]     dq_reg [0:NS];
    logic [F0_W-1:0]        dd_reg [0:NS];
    logic                   dsat_reg [0:NS];
    logic                   dzero_reg [0:NS];

    // phase stages
    logic               p0_v_reg, p1_v_reg, p2_v_reg, p3_v_reg;
    ctl_t               p0_c_reg, p1_c_reg, p2_c_reg, p3_c_reg;
    logic [PROD_W-1:0]  p0_mp_reg;
    logic [PB-1:0]      p0_ph_reg;
    logic [PB-1:0]      p0_lp_reg;
    logic [PB-1:0]      p0_ps_reg, p1_ps_reg, p2_ps_reg, p3_ps_reg;
    logic [RATIO_W-1:0] p0_ratio_reg, p1_ratio_reg, ratio_reg;
    logic [MAG_W-1:0]   p1_mag_reg;
    logic [EAW-1:0]     p1_sum_reg;
    logic [62:0]        p2_xp_reg;
    logic [EAW-1:0]     p2_pp_reg;
    logic [MAG_W-1:0]   p3_x0_reg;

    logic [31:0]        ph_round;
    logic [PB-1:0]      ph_next;
    logic [PROD_W-1:0]  mp_next;
    logic [RATIO_W-1:0] ratio_next;
    logic [PB-1:0]      d_next;
    logic [EAW-1:0]     sum_next;
    logic [RATIO_W-1:0] ratio_eff;
    logic [EAW+RATIO_W-1:0] pp_next;
    logic [62:0]        xp_next;
    logic [EAW-1:0]     adv_round;
    logic [PB-1:0]      psum_next;

    // rotating cordic
    logic                   rv_reg [0:NS];
    ctl_t                   rc_reg [0:NS];
    logic signed [VW-1:0]   rx_reg [0:NS];
    logic signed [VW-1:0]   ry_reg [0:NS];
    logic signed [ZW-1:0]   rz_reg [0:NS];
    logic                   rflip_reg [0:NS];

    // sign and output stages
    logic                 f_v_reg;
    ctl_t                 f_c_reg;
    logic signed [VW-1:0] f_x_reg, f_y_reg;
    logic                 q_v_reg;
    logic                 q_up_reg;
    logic                 q_last_reg;
    logic signed [RES_W-1:0] q_re_reg, q_im_reg;
    logic [2*RES_W-1:0]   q_rd_reg;
    logic signed [RES_W-1:0] out_re, out_im;

    // memories
    logic [PB-1:0]        last_phase [NBINS];
    logic [PB-1:0]        phase_sum [NBINS];
    logic [2*RES_W-1:0]   shifted_bins [NBINS];

    assign en            = !q_v_reg || m_axis_tready;
    assign s_axis_tready = en && !clr_busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // clearing pass, bin position and expected advance
    // ------------------------------------------------------------------------
    assign erem_sum = {1'b0, erem_reg} + (IW+1)'(E_REM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            pos_reg      <= '0;
            e_reg        <= '0;
            erem_reg     <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == NW'(NBINS - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (accept)
            begin
                if (pos_reg == IW'(FFT_SIZE - 1))
                begin
                    pos_reg  <= '0;
                    e_reg    <= '0;
                    erem_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + IW'(1);
                    if (erem_sum >= (IW+1)'(FFT_SIZE))
                    begin
                        erem_reg <= IW'(erem_sum - (IW+1)'(FFT_SIZE));
                        e_reg    <= e_reg + EAW'(E_QUO) + EAW'(1);
                    end
                    else
                    begin
                        erem_reg <= erem_sum[IW-1:0];
                        e_reg    <= e_reg + EAW'(E_QUO);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (en)
            s0_v_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_c_reg.lower <= (32'(pos_reg) < NBINS);
            s0_c_reg.first <= (pos_reg == '0);
            s0_c_reg.last  <= (pos_reg == IW'(FFT_SIZE - 1));
            s0_c_reg.idx   <= pos_reg;
            s0_c_reg.e     <= e_reg;
            s0_re_reg      <= s_axis_tdata[BIN_W-1:0];
            s0_im_reg      <= s_axis_tdata[2*BIN_W-1:BIN_W];
            s0_d_reg       <= s_axis_tdata[2*BIN_W+F0_W-1:2*BIN_W];
            s0_n_reg       <= {1'b0, s_axis_tdata[2*BIN_W+2*F0_W-1:2*BIN_W+F0_W], 12'b0}
                              + 33'(s_axis_tdata[2*BIN_W+F0_W-1:2*BIN_W+1]);
        end
    end

    // ------------------------------------------------------------------------
    // vectoring cordic entry and divider setup
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vv_reg[0] <= 1'b0;
        else if (en)
            vv_reg[0] <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [VW-1:0] x0, y0;
        x0 = {{(VW-BIN_W-FRAC_BITS){s0_re_reg[BIN_W-1]}}, s0_re_reg, {FRAC_BITS{1'b0}}};
        y0 = {{(VW-BIN_W-FRAC_BITS){s0_im_reg[BIN_W-1]}}, s0_im_reg, {FRAC_BITS{1'b0}}};
        if (en)
        begin
            vc_reg[0]    <= s0_c_reg;
            vzero_reg[0] <= (s0_re_reg == '0) && (s0_im_reg == '0);
            if (x0 < 0)
            begin
                vx_reg[0] <= -x0;
                vy_reg[0] <= -y0;
                vz_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                vx_reg[0] <= x0;
                vy_reg[0] <= y0;
                vz_reg[0] <= '0;
            end
            drem_reg[0]  <= F0_W'(s0_n_reg[32:16]);
            dlo_reg[0]   <= s0_n_reg[15:0];
            dq_reg[0]    <= '0;
            dd_reg[0]    <= s0_d_reg;
            dzero_reg[0] <= (s0_d_reg == '0);
            dsat_reg[0]  <= {3'b0, s0_n_reg} >= {s0_d_reg, 16'b0};
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_vec
            logic signed [VW-1:0] dx, dy, x_next, y_next;
            logic [31:0]          z_next;
            logic [F0_W:0]        rem_sh;
            logic [F0_W-1:0]      rem_next;
            logic [RATIO_W-1:0]   q_next;
            logic [DIV_STEPS-1:0] lo_next;

            always_comb
            begin
                dx = vy_reg[k] >>> k;
                dy = vx_reg[k] >>> k;
                if (vy_reg[k] > 0)
                begin
                    x_next = vx_reg[k] + dx;
                    y_next = vy_reg[k] - dy;
                    z_next = vz_reg[k] + ATAN_TURN[k];
                end
                else
                begin
                    x_next = vx_reg[k] - dx;
                    y_next = vy_reg[k] + dy;
                    z_next = vz_reg[k] - ATAN_TURN[k];
                end
                rem_sh = {drem_reg[k], dlo_reg[k][DIV_STEPS-1]};
                if (k < DIV_STEPS)
                begin
                    lo_next = {dlo_reg[k][DIV_STEPS-2:0], 1'b0};
                    if (rem_sh >= {1'b0, dd_reg[k]})
                    begin
                        rem_next = F0_W'(rem_sh - {1'b0, dd_reg[k]});
                        q_next   = {dq_reg[k][RATIO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh[F0_W-1:0];
                        q_next   = {dq_reg[k][RATIO_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    lo_next  = dlo_reg[k];
                    rem_next = drem_reg[k];
                    q_next   = dq_reg[k];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vv_reg[k+1] <= 1'b0;
                else if (en)
                    vv_reg[k+1] <= vv_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vc_reg[k+1]    <= vc_reg[k];
                    vzero_reg[k+1] <= vzero_reg[k];
                    vx_reg[k+1]    <= x_next;
                    vy_reg[k+1]    <= y_next;
                    vz_reg[k+1]    <= z_next;
                    drem_reg[k+1]  <= rem_next;
                    dlo_reg[k+1]   <= lo_next;
                    dq_reg[k+1]    <= q_next;
                    dd_reg[k+1]    <= dd_reg[k];
                    dsat_reg[k+1]  <= dsat_reg[k];
                    dzero_reg[k+1] <= dzero_reg[k];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------------
    // phase stages
    // ------------------------------------------------------------------------
    always_comb
    begin
        ph_round = vz_reg[NS] + (32'd1 << (31 - PB));
        ph_next  = vzero_reg[NS] ? '0 : ph_round[31 -: PB];
        mp_next  = vzero_reg[NS] ? '0
                 : {30'b0, vx_reg[NS][33:0]} * {34'b0, INV_GAIN};
        priority if (dzero_reg[NS])
            ratio_next = RATIO_ONE;
        else if (dsat_reg[NS])
            ratio_next = RATIO_MAX;
        else
            ratio_next = dq_reg[NS];

        ratio_eff = p0_c_reg.first ? p0_ratio_reg : ratio_reg;
        d_next    = p0_ph_reg - p0_lp_reg - p0_c_reg.e[PB-1:0];
        sum_next  = p0_c_reg.e + {{RATIO_FRAC{d_next[PB-1]}}, d_next};

        pp_next   = p1_sum_reg * p1_ratio_reg;
        xp_next   = {30'b0, p1_mag_reg} * {33'b0, INV_GAIN};

        adv_round = p2_pp_reg + EAW'(1 << (RATIO_FRAC - 1));
        psum_next = p2_ps_reg + adv_round[EAW-1:RATIO_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg  <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            ratio_reg <= RATIO_ONE;
        end
        else if (en)
        begin
            p0_v_reg <= vv_reg[NS];
            p1_v_reg <= p0_v_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (p0_v_reg && p0_c_reg.first)
                ratio_reg <= p0_ratio_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_c_reg     <= vc_reg[NS];
            p0_mp_reg    <= mp_next;
            p0_ph_reg    <= ph_next;
            p0_ratio_reg <= ratio_next;
            p0_lp_reg    <= last_phase[vc_reg[NS].idx[NW-1:0]];
            p0_ps_reg    <= phase_sum[vc_reg[NS].idx[NW-1:0]];

            p1_c_reg     <= p0_c_reg;
            p1_mag_reg   <= p0_mp_reg[62:30];
            p1_sum_reg   <= sum_next;
            p1_ratio_reg <= ratio_eff;
            p1_ps_reg    <= p0_ps_reg;

            p2_c_reg     <= p1_c_reg;
            p2_xp_reg    <= xp_next;
            p2_pp_reg    <= pp_next[EAW-1:0];
            p2_ps_reg    <= p1_ps_reg;

            p3_c_reg     <= p2_c_reg;
            p3_x0_reg    <= p2_xp_reg[62:30];
            p3_ps_reg    <= psum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            last_phase[clr_cnt_reg] <= '0;
        else if (en && vv_reg[NS] && vc_reg[NS].lower)
            last_phase[vc_reg[NS].idx[NW-1:0]] <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            phase_sum[clr_cnt_reg] <= '0;
        else if (en && p2_v_reg && p2_c_reg.lower)
            phase_sum[p2_c_reg.idx[NW-1:0]] <= psum_next;
    end

    // ------------------------------------------------------------------------
    // rotating cordic
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= p3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] t, t_add, t_fix;
        t     = {p3_ps_reg, {(32-PB){1'b0}}};
        t_add = t + 32'h4000_0000;
        t_fix = t_add[31] ? t - 32'h8000_0000 : t;
        if (en)
        begin
            rc_reg[0]    <= p3_c_reg;
            rflip_reg[0] <= t_add[31];
            rx_reg[0]    <= {{(VW-MAG_W){1'b0}}, p3_x0_reg};
            ry_reg[0]    <= '0;
            rz_reg[0]    <= {{(ZW-32){t_fix[31]}}, t_fix};
        end
    end

    generate
        for (k = 0; k < NS; k++)
        begin : g_rot
            logic signed [VW-1:0] dx, dy, x_next, y_next;
            logic signed [ZW-1:0] z_next, a;

            always_comb
            begin
                dx = ry_reg[k] >>> k;
                dy = rx_reg[k] >>> k;
                a  = {{(ZW-32){1'b0}}, ATAN_TURN[k]};
                if (rz_reg[k] >= 0)
                begin
                    x_next = rx_reg[k] - dx;
                    y_next = ry_reg[k] + dy;
                    z_next = rz_reg[k] - a;
                end
                else
                begin
                    x_next = rx_reg[k] + dx;
                    y_next = ry_reg[k] - dy;
                    z_next = rz_reg[k] + a;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    rv_reg[k+1] <= 1'b0;
                else if (en)
                    rv_reg[k+1] <= rv_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rc_reg[k+1]    <= rc_reg[k];
                    rflip_reg[k+1] <= rflip_reg[k];
                    rx_reg[k+1]    <= x_next;
                    ry_reg[k+1]    <= y_next;
                    rz_reg[k+1]    <= z_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------------
    // sign, rounding, bin store and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= rv_reg[NS];
            q_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [VW-1:0] xr, yr;
        logic signed [RES_W-1:0] re_s, im_s;
        xr   = (f_x_reg + VW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        yr   = (f_y_reg + VW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        re_s = sat_res(xr);
        im_s = sat_res(yr);
        if (en)
        begin
            f_c_reg    <= rc_reg[NS];
            f_x_reg    <= rflip_reg[NS] ? -rx_reg[NS] : rx_reg[NS];
            f_y_reg    <= rflip_reg[NS] ? -ry_reg[NS] : ry_reg[NS];

            q_up_reg   <= !f_c_reg.lower;
            q_last_reg <= f_c_reg.last;
            q_re_reg   <= re_s;
            q_im_reg   <= im_s;
            if (f_v_reg && f_c_reg.lower)
                shifted_bins[f_c_reg.idx[NW-1:0]] <= {im_s, re_s};
            q_rd_reg   <= shifted_bins[NW'((IW+1)'(FFT_SIZE) - {1'b0, f_c_reg.idx})];
        end
    end

    always_comb
    begin
        logic signed [VW-1:0] neg_im;
        neg_im = -{{(VW-RES_W){q_rd_reg[2*RES_W-1]}}, q_rd_reg[2*RES_W-1:RES_W]};
        out_re = q_up_reg ? q_rd_reg[RES_W-1:0] : q_re_reg;
        out_im = q_up_reg ? sat_res(neg_im) : q_im_reg;
    end

    assign m_axis_tvalid = q_v_reg;
    assign m_axis_tlast  = q_last_reg;
    assign m_axis_tdata  = {{(OUT_W-2*RES_W){1'b0}}, out_im, out_re};

endmodule

// ===== tb/pvbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbs_checker
// Watches both streams of the phase vocoder bin shifter, predicts each shifted
// bin from the accepted input requests and compares the output requests with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pvbs_checker #(
    parameter int FFT_SIZE   = 512,
    parameter int HOP_SIZE   = 128,
    parameter int PHASE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [pvbs_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [pvbs_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                       m_axis_tlast,
    output int                         pending,
    output int                         fail_count
);
    import pvbs_pkg::*;

    localparam int NBINS = FFT_SIZE / 2 + 1;
    localparam logic [31:0] PH_MASK = (32'd1 << PHASE_BITS) - 32'd1;

    typedef struct {
        logic signed [RES_W-1:0] re;
        logic signed [RES_W-1:0] im;
        logic                    last;
    } shifted_bin_t;

    shifted_bin_t shifted_bin_q[$];

    logic [31:0]  last_ph [NBINS];
    logic [31:0]  acc_ph  [NBINS];
    longint       kept_re [NBINS];
    longint       kept_im [NBINS];
    int unsigned  bin_pos;
    logic [63:0]  ratio;

    function automatic longint clamp25(input longint v);
        if (v > 16777215)
            return 16777215;
        if (v < -16777216)
            return -16777216;
        return v;
    endfunction

    function automatic void to_polar(input longint re, input longint im,
                                     output logic [63:0] mag, output logic [31:0] ph);
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic [31:0] z;
        logic [63:0] ux;
        x = re * 256;
        y = im * 256;
        z = 32'd0;
        if (re == 0 && im == 0)
        begin
            mag = 64'd0;
            ph  = 32'd0;
            return;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += ATAN_TURN[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ATAN_TURN[i];
            end
        end
        ux  = x;
        mag = (ux * 64'(INV_GAIN)) >> 30;
        z   = z + (32'd1 << (31 - PHASE_BITS));
        ph  = (z >> (32 - PHASE_BITS)) & PH_MASK;
    endfunction

    function automatic void from_polar(input logic [63:0] mag, input logic [31:0] ph,
                                       output longint re, output longint im);
        logic [31:0] t;
        logic [31:0] tp;
        logic [63:0] um;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        t    = (ph & PH_MASK) << (32 - PHASE_BITS);
        tp   = t + 32'h4000_0000;
        flip = tp[31];
        um   = (mag * 64'(INV_GAIN)) >> 30;
        x    = longint'(um);
        y    = 0;
        if (flip)
            t = t - 32'h8000_0000;
        z = longint'(signed'(t));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TURN[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TURN[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        re = clamp25((x + 128) >>> 8);
        im = clamp25((y + 128) >>> 8);
    endfunction

    function automatic shifted_bin_t shift_bin(input logic [IN_W-1:0] req);
        shifted_bin_t r;
        int unsigned  i;
        logic [63:0]  of0;
        logic [63:0]  cf0;
        logic [63:0]  q;
        logic [63:0]  mag;
        logic [31:0]  ph;
        logic [63:0]  e_full;
        logic [31:0]  d;
        logic [63:0]  dev;
        logic [63:0]  sum;
        logic [63:0]  adv;
        longint       re;
        longint       im;
        i = (bin_pos >= FFT_SIZE) ? 0 : bin_pos;
        if (i == 0)
        begin
            of0 = 64'(req[67:48]);
            cf0 = 64'(req[87:68]);
            if (of0 == 0)
                ratio = 64'd4096;
            else
            begin
                q = (cf0 * 64'd4096 + of0 / 2) / of0;
                ratio = (q > 64'd65535) ? 64'd65535 : q;
            end
        end
        if (i < NBINS)
        begin
            to_polar(longint'(signed'(req[23:0])), longint'(signed'(req[47:24])), mag, ph);
            e_full = ((64'(i) * HOP_SIZE) << PHASE_BITS) / FFT_SIZE;
            d      = (ph - last_ph[i] - e_full[31:0]) & PH_MASK;
            dev    = d[PHASE_BITS-1] ? (64'(d) - (64'd1 << PHASE_BITS)) : 64'(d);
            sum    = e_full + dev;
            adv    = ((sum * ratio + 64'd2048) >> 12) & 64'(PH_MASK);
            acc_ph[i]  = (acc_ph[i] + adv[31:0]) & PH_MASK;
            last_ph[i] = ph;
            from_polar(mag, acc_ph[i], re, im);
            kept_re[i] = re;
            kept_im[i] = im;
        end
        else
        begin
            re = kept_re[FFT_SIZE - i];
            im = clamp25(-kept_im[FFT_SIZE - i]);
        end
        r.re   = re[RES_W-1:0];
        r.im   = im[RES_W-1:0];
        r.last = (i == FFT_SIZE - 1);
        bin_pos = (i + 1 >= FFT_SIZE) ? 0 : i + 1;
        return r;
    endfunction

    assign pending = shifted_bin_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        shifted_bin_t want;
        logic signed [RES_W-1:0] got_re;
        logic signed [RES_W-1:0] got_im;
        if (!rst_n)
        begin
            shifted_bin_q.delete();
            for (int k = 0; k < NBINS; k++)
            begin
                last_ph[k] = 0;
                acc_ph[k]  = 0;
                kept_re[k] = 0;
                kept_im[k] = 0;
            end
            bin_pos    = 0;
            ratio      = 64'd4096;
            fail_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                shifted_bin_q.push_back(shift_bin(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_re = m_axis_tdata[24:0];
                got_im = m_axis_tdata[49:25];
                if (shifted_bin_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output request re=%0d im=%0d last=%0b",
                                 got_re, got_im, m_axis_tlast);
                end
                else
                begin
                    want = shifted_bin_q.pop_front();
                    if (got_re !== want.re || got_im !== want.im
                        || m_axis_tlast !== want.last || m_axis_tdata[55:50] !== 6'd0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b fill=%0h",
                                     want.re, want.im, want.last, got_re, got_im,
                                     m_axis_tlast, m_axis_tdata[55:50]);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of spectrum bins into the phase vocoder bin shifter with
// bursty input and a stalling output, starting with extreme bins and pitch
// pairs, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pvbs_pkg::*;

    localparam int FFT_SIZE   = 512;
    localparam int NBINS      = FFT_SIZE / 2 + 1;
    localparam int N_FRAMES   = 3;
    localparam int CYCLE_CAP  = 100000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;
    int                pending;
    int                fail_count;
    int                burst_left = 0;
    int                cycles = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    phase_vocoder_bin_shift i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pvbs_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // receiver stall pattern steps through four modes in turn
    always @(posedge clk)
    begin
        int mode;
        mode = (cycles / 300) % 4;
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ((cycles % 4) == 0);
            default: m_axis_tready <= ((cycles % 40) < 25);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [BIN_W-1:0] rand_part();
        case ($urandom_range(0, 3))
            0: return BIN_W'($urandom);
            1: return BIN_W'($signed($urandom_range(0, 200)) - 100);
            2: return BIN_W'($signed($urandom_range(0, 131072)) - 65536);
            default: return BIN_W'($urandom & 32'h00FF_FFFF);
        endcase
    endfunction

    task automatic send(input logic [BIN_W-1:0] re, input logic [BIN_W-1:0] im,
                        input logic [F0_W-1:0] of0, input logic [F0_W-1:0] cf0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cf0, of0, im, re};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    initial
    begin
        logic [BIN_W-1:0] dre [16];
        logic [BIN_W-1:0] dim [16];
        logic [F0_W-1:0]  of0;
        logic [F0_W-1:0]  cf0;
        logic [BIN_W-1:0] re;
        logic [BIN_W-1:0] im;
        dre = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 24'h7FFFFF,
                24'h800000, 24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFF, 24'h000000,
                24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h000100};
        dim = '{24'h000000, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                24'h800000, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 24'hFFFFFF,
                24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFF00};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int f = 0; f < N_FRAMES; f++)
        begin
            if (f == 2)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            for (int b = 0; b < FFT_SIZE; b++)
            begin
                re  = rand_part();
                im  = rand_part();
                of0 = F0_W'($urandom);
                cf0 = F0_W'($urandom);
                if (b == 0)
                begin
                    case (f)
                        0: of0 = '0;
                        1:
                        begin
                            of0 = 20'd1;
                            cf0 = 20'hFFFFF;
                        end
                        default:
                        begin
                            of0 = F0_W'($urandom_range(1000, 4000));
                            cf0 = of0 + F0_W'($urandom_range(0, 800));
                        end
                    endcase
                end
                if (b < 16 && (f == 0 || f == 1))
                begin
                    re = dre[b];
                    im = dim[b];
                end
                else if ($urandom_range(0, 40) == 0)
                begin
                    re = '0;
                    im = '0;
                end
                send(re, im, of0, cf0);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pvbs_pkg.sv
hdl/phase_vocoder_bin_shift.sv
tb/pvbs_checker.sv
tb/tb_top.sv
